// ===== design/relay_duplicate_filter_unit_defines.svh =====
// Assertion macros shared by the relay duplicate filter.
`ifndef RELAY_DUPLICATE_FILTER_UNIT_DEFINES_SVH
`define RELAY_DUPLICATE_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on aclk and disabled in reset.
`define RDF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on aclk and disabled in reset.
`define RDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rdf_pkg.sv =====
// Shared types and codes for the relay duplicate filter.
package rdf_pkg;

    localparam logic [1:0] REASON_NONE = 2'd0;
    localparam logic [1:0] REASON_TTL  = 2'd1;
    localparam logic [1:0] REASON_DUP  = 2'd2;

    // One classified frame on its way from the front end to the table engine.
    typedef struct packed {
        logic        ttl_drop;
        logic [63:0] sender;
        logic [63:0] seq;
        logic [31:0] now;
    } cmd_t;

endpackage

// ===== design/rdf_front.sv =====
// Front end: accepts frames, classifies them and queues them for the table engine.
module rdf_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_hop_limit,
    input  logic [63:0]   s_sender_id,
    input  logic [63:0]   s_msg_seq,
    input  logic [31:0]   s_now_ms,
    output logic          cmd_valid,
    output rdf_pkg::cmd_t cmd,
    input  logic          cmd_pop
);

    rdf_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    fill_reg, fill_next;
    logic          push;
    rdf_pkg::cmd_t new_cmd;

    // Classification: a zero hop count needs no table work.
    always_comb begin
        new_cmd.ttl_drop = (s_hop_limit == 8'd0);
        new_cmd.sender   = s_sender_id;
        new_cmd.seq      = s_msg_seq;
        new_cmd.now      = s_now_ms;
    end

    assign s_ready   = (fill_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    // Queue pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// ===== design/rdf_back.sv =====
// Table engine: compacts and searches the seen table, records new frames, holds the result.
module rdf_back #(
    parameter int TABLE_ENTRIES = 16,
    parameter int ID_BYTES      = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [31:0]   window,
    input  logic          cmd_valid,
    input  rdf_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          out_forward,
    output logic [1:0]    out_reason
);

    localparam int ID_W  = 8 * ID_BYTES;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EVAL, S_RECORD, S_OUT} state_t;

    state_t             state_reg;
    rdf_pkg::cmd_t      cmd_reg;
    logic [CNT_W-1:0]   idx_reg, keep_reg, count_reg;
    logic [IDX_W-1:0]   ptr_reg;
    logic               dup_reg;
    logic               out_valid_reg, out_forward_reg;
    logic [1:0]         out_reason_reg;

    logic [ID_W-1:0]    mem_sender [TABLE_ENTRIES];
    logic [63:0]        mem_seq    [TABLE_ENTRIES];
    logic [31:0]        mem_time   [TABLE_ENTRIES];
    logic [ID_W-1:0]    rd_sender;
    logic [63:0]        rd_seq;
    logic [31:0]        rd_time;

    logic               rd_en, wr_en, keep_it, is_match;
    logic [IDX_W-1:0]   wr_addr;
    logic [ID_W-1:0]    wr_sender;
    logic [63:0]        wr_seq;
    logic [31:0]        wr_time;

    assign cmd_pop     = (state_reg == S_IDLE) && cmd_valid;
    assign out_valid   = out_valid_reg;
    assign out_forward = out_forward_reg;
    assign out_reason  = out_reason_reg;

    // Entry evaluation: keep young entries, flag a match among them.
    assign keep_it  = ((cmd_reg.now - rd_time) < window);
    assign is_match = (rd_sender == cmd_reg.sender[ID_W-1:0]) && (rd_seq == cmd_reg.seq);
    assign rd_en    = (state_reg == S_SCAN) && (idx_reg != count_reg);

    // Write port: compaction copies in EVAL, the new record in RECORD.
    always_comb begin
        wr_en     = 1'b0;
        wr_addr   = keep_reg[IDX_W-1:0];
        wr_sender = rd_sender;
        wr_seq    = rd_seq;
        wr_time   = rd_time;
        case (state_reg)
            S_EVAL: begin
                wr_en = keep_it;
            end
            S_RECORD: begin
                wr_en     = !dup_reg;
                wr_addr   = (count_reg < CNT_W'(TABLE_ENTRIES)) ?
                            count_reg[IDX_W-1:0] : ptr_reg;
                wr_sender = cmd_reg.sender[ID_W-1:0];
                wr_seq    = cmd_reg.seq;
                wr_time   = cmd_reg.now;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Table memory with registered read data.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_sender[wr_addr] <= wr_sender;
            mem_seq[wr_addr]    <= wr_seq;
            mem_time[wr_addr]   <= wr_time;
        end
        if (rd_en) begin
            rd_sender <= mem_sender[idx_reg[IDX_W-1:0]];
            rd_seq    <= mem_seq[idx_reg[IDX_W-1:0]];
            rd_time   <= mem_time[idx_reg[IDX_W-1:0]];
        end
    end

    // Sequencer: one read and one evaluate step per stored entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            ptr_reg         <= '0;
            out_valid_reg   <= 1'b0;
            idx_reg         <= '0;
            keep_reg        <= '0;
            dup_reg         <= 1'b0;
            out_forward_reg <= 1'b0;
            out_reason_reg  <= rdf_pkg::REASON_NONE;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (cmd_valid) begin
                        cmd_reg  <= cmd;
                        idx_reg  <= '0;
                        keep_reg <= '0;
                        dup_reg  <= 1'b0;
                        if (cmd.ttl_drop) begin
                            out_valid_reg   <= 1'b1;
                            out_forward_reg <= 1'b0;
                            out_reason_reg  <= rdf_pkg::REASON_TTL;
                            state_reg       <= S_OUT;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (idx_reg == count_reg) begin
                        count_reg <= keep_reg;
                        state_reg <= S_RECORD;
                    end else begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (keep_it) begin
                        keep_reg <= keep_reg + 1'b1;
                        if (is_match) begin
                            dup_reg <= 1'b1;
                        end
                    end
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_SCAN;
                end
                S_RECORD: begin
                    out_valid_reg <= 1'b1;
                    if (dup_reg) begin
                        out_forward_reg <= 1'b0;
                        out_reason_reg  <= rdf_pkg::REASON_DUP;
                    end else begin
                        out_forward_reg <= 1'b1;
                        out_reason_reg  <= rdf_pkg::REASON_NONE;
                        if (count_reg < CNT_W'(TABLE_ENTRIES)) begin
                            count_reg <= count_reg + 1'b1;
                        end else if (ptr_reg == IDX_W'(TABLE_ENTRIES - 1)) begin
                            ptr_reg <= '0;
                        end else begin
                            ptr_reg <= ptr_reg + 1'b1;
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_ready) begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/relay_duplicate_filter_unit.sv =====
// Top level of the relay duplicate filter: window register, front end and table engine.
//
//  Channel  Direction  Handshake              Contents
//  s_       in         s_valid / s_ready      hop limit, sender id, sequence, time
//  m_       out        m_valid / m_ready      forward flag, drop reason
//  cfg_w    in         cfg_wvalid / cfg_wready  seen window in milliseconds
//
// A frame with zero hop count goes from idle straight to the output state of the
// table engine; any other frame takes one memory read and one evaluate per entry
// stored before it, then a record step and the output state.
// A two-deep queue takes frames while the engine works or a result waits.
// Reset empties the table and queue and loads the window with 30000; the
// table memory itself is not cleared.
`include "relay_duplicate_filter_unit_defines.svh"

module relay_duplicate_filter_unit #(
    parameter int TABLE_ENTRIES = 16,
    parameter int ID_BYTES      = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_hop_limit,
    input  logic [63:0] s_sender_id,
    input  logic [63:0] s_msg_seq,
    input  logic [31:0] s_now_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_forward,
    output logic [1:0]  m_drop_reason,
    input  logic        cfg_wvalid,
    output logic        cfg_wready,
    input  logic [31:0] cfg_wdata
);

    logic [31:0]   window_reg;
    logic          cmd_valid, cmd_pop;
    rdf_pkg::cmd_t cmd;

    // Window register; writes are always taken.
    assign cfg_wready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= 32'd30000;
        end else if (cfg_wvalid) begin
            window_reg <= cfg_wdata;
        end
    end

    rdf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_hop_limit (s_hop_limit),
        .s_sender_id (s_sender_id),
        .s_msg_seq   (s_msg_seq),
        .s_now_ms    (s_now_ms),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    rdf_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ID_BYTES      (ID_BYTES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .window      (window_reg),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_forward (m_forward),
        .out_reason  (m_drop_reason)
    );

    // A forwarded frame carries no drop reason, a dropped one always does.
    `RDF_ASSERT_IMPL(a_fwd_reason, m_valid, (m_forward == (m_drop_reason == rdf_pkg::REASON_NONE)), "forward flag and drop reason disagree")
    // The engine leaves its output state once a result transaction completes.
    `RDF_ASSERT_NEXT(a_out_clears, (m_valid && m_ready), !m_valid, "result shown twice")
    // A queued frame is only taken while no result is pending.
    `RDF_ASSERT_IMPL(a_pop_idle, cmd_pop, (cmd_valid && !m_valid), "frame taken while result pending")

endmodule

// ===== bench/relay_duplicate_filter_unit_tb.sv =====
// Self-checking testbench for the relay duplicate filter: directed and random traffic against a table model.
`timescale 1ns / 1ps

module relay_duplicate_filter_unit_tb;

    localparam int TABLE_DEPTH = 16;
    localparam int RUN_LIMIT   = 400000;

    typedef struct {
        logic [7:0]  hops;
        logic [63:0] sender;
        logic [63:0] seq;
        logic [31:0] now;
    } frame_t;

    typedef struct {
        logic       fwd;
        logic [1:0] reason;
    } verdict_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_hop_limit;
    logic [63:0] s_sender_id;
    logic [63:0] s_msg_seq;
    logic [31:0] s_now_ms;
    logic        m_valid;
    logic        m_ready;
    logic        m_forward;
    logic [1:0]  m_drop_reason;
    logic        cfg_wvalid;
    logic        cfg_wready;
    logic [31:0] cfg_wdata;

    relay_duplicate_filter_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_hop_limit(s_hop_limit),
        .s_sender_id(s_sender_id), .s_msg_seq(s_msg_seq), .s_now_ms(s_now_ms),
        .m_valid(m_valid), .m_ready(m_ready), .m_forward(m_forward),
        .m_drop_reason(m_drop_reason),
        .cfg_wvalid(cfg_wvalid), .cfg_wready(cfg_wready), .cfg_wdata(cfg_wdata)
    );

    // Seen-frame table model.
    logic [63:0] seen_sender [TABLE_DEPTH];
    logic [63:0] seen_seq    [TABLE_DEPTH];
    logic [31:0] seen_time   [TABLE_DEPTH];
    int          seen_count;
    int          overwrite_slot;
    logic [31:0] window_ms;

    frame_t   pending_frames[$];
    verdict_t expected_verdicts[$];
    int       mismatches;
    int       cycle_count;
    bit       idle_allowed;
    bit       hold_request;
    int       send_gap;
    int       recv_gap;
    int       hold_cycles;

    // Compute the verdict for one accepted frame and update the table.
    function automatic verdict_t classify_frame(frame_t f);
        verdict_t v;
        int keep;
        int slot;
        keep = 0;
        if (f.hops == 8'd0) begin
            v.fwd = 1'b0;
            v.reason = rdf_pkg::REASON_TTL;
            return v;
        end
        for (int i = 0; i < seen_count; i++) begin
            if (f.now - seen_time[i] < window_ms) begin
                seen_sender[keep] = seen_sender[i];
                seen_seq[keep] = seen_seq[i];
                seen_time[keep] = seen_time[i];
                keep++;
            end
        end
        seen_count = keep;
        for (int i = 0; i < seen_count; i++) begin
            if (seen_sender[i] == f.sender && seen_seq[i] == f.seq) begin
                v.fwd = 1'b0;
                v.reason = rdf_pkg::REASON_DUP;
                return v;
            end
        end
        if (seen_count < TABLE_DEPTH) begin
            slot = seen_count;
            seen_count++;
        end else begin
            slot = overwrite_slot;
            overwrite_slot = (overwrite_slot + 1) % TABLE_DEPTH;
        end
        seen_sender[slot] = f.sender;
        seen_seq[slot] = f.seq;
        seen_time[slot] = f.now;
        v.fwd = 1'b1;
        v.reason = rdf_pkg::REASON_NONE;
        return v;
    endfunction

    // Clock generation.
    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Driver: offers queued frames, with random gaps between transactions.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_verdicts.push_back(classify_frame(pending_frames.pop_front()));
            end
            if (!s_valid || s_ready) begin
                @(negedge aclk);
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_frames.size() > 0) begin
                    s_valid <= 1'b1;
                    s_hop_limit <= pending_frames[0].hops;
                    s_sender_id <= pending_frames[0].sender;
                    s_msg_seq <= pending_frames[0].seq;
                    s_now_ms <= pending_frames[0].now;
                    if (idle_allowed && $urandom_range(0, 5) == 0) begin
                        send_gap <= $urandom_range(1, 7);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transaction against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: forward %0b reason %0d",
                             m_forward, m_drop_reason);
                end
            end else begin
                verdict_t e;
                e = expected_verdicts.pop_front();
                if (e.fwd !== m_forward || e.reason !== m_drop_reason) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected forward %0b reason %0d, got %0b %0d",
                                 e.fwd, e.reason, m_forward, m_drop_reason);
                    end
                end
            end
        end
    end

    // Receiver backpressure, including a long hold when requested.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap <= 0;
            hold_cycles <= 0;
        end else if (hold_request && hold_cycles == 0) begin
            hold_cycles <= 300;
            m_ready <= 1'b0;
        end else if (hold_cycles > 1) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            hold_cycles <= 0;
            recv_gap <= recv_gap - 1;
            m_ready <= 1'b0;
        end else begin
            hold_cycles <= 0;
            m_ready <= 1'b1;
            if (idle_allowed && $urandom_range(0, 5) == 0) begin
                recv_gap <= $urandom_range(1, 7);
            end
        end
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("[relay_duplicate_filter_unit] ERROR");
            $finish;
        end
    end

    function automatic frame_t make_frame(logic [7:0] h, logic [63:0] s,
                                          logic [63:0] q, logic [31:0] t);
        frame_t f;
        f.hops = h;
        f.sender = s;
        f.seq = q;
        f.now = t;
        return f;
    endfunction

    task automatic drain_all();
        while (pending_frames.size() > 0 || s_valid || expected_verdicts.size() > 0) begin
            @(posedge aclk);
        end
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_window(logic [31:0] value);
        @(negedge aclk);
        cfg_wvalid <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        while (!cfg_wready) @(posedge aclk);
        window_ms = value;
        @(negedge aclk);
        cfg_wvalid <= 1'b0;
    endtask

    // Random phase: a small pool of senders and sequences so duplicates are common.
    task automatic queue_random(int count, logic [31:0] t0, int step_max);
        logic [31:0] t;
        logic [63:0] snd;
        logic [63:0] sq;
        t = t0;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                snd = {$urandom, $urandom};
                sq = {$urandom, $urandom};
            end else begin
                snd = {$urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : 32'h0,
                       32'(32'hA5A5_0000 + $urandom_range(0, 3))};
                sq = {$urandom_range(0, 1) == 0 ? 32'hFFFF_FFFF : 32'h0,
                      32'($urandom_range(0, 7))};
            end
            t = t + 32'($urandom_range(0, step_max));
            pending_frames.push_back(make_frame(
                $urandom_range(0, 7) == 0 ? 8'd0 : 8'($urandom_range(1, 255)), snd, sq, t));
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_hop_limit = '0;
        s_sender_id = '0;
        s_msg_seq = '0;
        s_now_ms = '0;
        m_ready = 1'b0;
        cfg_wvalid = 1'b0;
        cfg_wdata = '0;
        idle_allowed = 1'b1;
        hold_request = 1'b0;
        seen_count = 0;
        overwrite_slot = 0;
        window_ms = 32'd30000;
        mismatches = 0;
        cycle_count = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: field extremes, hop count zero, duplicates, wrap of time.
        pending_frames.push_back(make_frame(8'd0, '1, '1, '1));
        pending_frames.push_back(make_frame(8'd255, '1, '1, 32'hFFFF_FFF0));
        pending_frames.push_back(make_frame(8'd1, '1, '1, 32'h0000_0010));
        pending_frames.push_back(make_frame(8'd0, '1, '1, 32'h0000_0011));
        pending_frames.push_back(make_frame(8'd1, '0, '0, 32'h0000_0020));
        pending_frames.push_back(make_frame(8'd1, '0, '0, 32'h0000_7530));
        pending_frames.push_back(make_frame(8'd1, '0, '0, 32'h0000_7540));
        drain_all();

        // Zero window: everything expires.
        write_window(32'd0);
        pending_frames.push_back(make_frame(8'd3, 64'h5, 64'h5, 32'd100));
        pending_frames.push_back(make_frame(8'd3, 64'h5, 64'h5, 32'd100));
        drain_all();

        // Maximum window: fill past capacity so the round-robin slot advances.
        write_window(32'hFFFF_FFFF);
        for (int i = 0; i < 20; i++) begin
            pending_frames.push_back(make_frame(8'd9, 64'(i), 64'h77, 32'(i)));
        end
        pending_frames.push_back(make_frame(8'd9, 64'd0, 64'h77, 32'd30));
        pending_frames.push_back(make_frame(8'd9, 64'd19, 64'h77, 32'd31));
        drain_all();

        // Long receiver hold while the sender keeps offering.
        hold_request = 1'b1;
        queue_random(40, 32'd1000, 50);
        repeat (5) @(posedge aclk);
        hold_request = 1'b0;
        drain_all();

        write_window(32'd1);
        queue_random(60, 32'hFFFF_FF00, 3);
        drain_all();

        write_window(32'd500);
        queue_random(150, 32'h8000_0000, 40);
        drain_all();

        // Final stretch without idling.
        write_window(32'd30000);
        idle_allowed = 1'b0;
        queue_random(130, 32'hFFFF_0000, 400);
        drain_all();

        if (mismatches == 0) begin
            $display("[relay_duplicate_filter_unit] OK");
        end else begin
            $display("[relay_duplicate_filter_unit] ERROR");
        end
        $finish;
    end

endmodule
